// ===== rtl/bpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bpq_pkg
// shared types and codes of the bucket priority queue
// ----------------------------------------------------------------------------
package bpq_pkg;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_PUSH  = 8'b00000010,
        S_PUSHW = 8'b00000100,
        S_SCAN  = 8'b00001000,
        S_POPT  = 8'b00010000,
        S_POPE  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_CLEAR = 8'b10000000
    } t_state;

endpackage

// ===== rtl/bucket_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// bucket_priority_queue_core
// min-priority queue of linked per-key stacks in shared entry memory
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)         tuser
// s_axis   in   func[0], key[16:1], value[48:17]  -
// m_axis   out  out_value[31:0], out_key[41:32],  -
//               status[43:42]
// a push passes S_PUSH and S_PUSHW into the result register via S_OUT; a pop
// passes S_SCAN, S_POPT and S_POPE, scanning empty buckets upward from the
// lowest-key pointer; the bucket count memory is read one bucket per cycle.
// after reset a clearing pass zeroes the bucket counts; input is held off
// until it ends. the result register holds while m_axis_tready is low; a
// new item is taken once the result register is free.
// ----------------------------------------------------------------------------
module bucket_priority_queue_core
    import bpq_pkg::*;
#(
    parameter int NUM_BUCKETS = 1024,
    parameter int CAPACITY    = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // func, key, value, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // out_value, out_key, status, zero fill
);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int EW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = $clog2(NUM_BUCKETS + 1);

    logic [EW-1:0] bucket_top [NUM_BUCKETS];
    logic [CW-1:0] bucket_count [NUM_BUCKETS];
    logic [31:0]   entry_value [CAPACITY];
    logic [EW-1:0] entry_link [CAPACITY];

    t_state r_state;
    logic [EW-1:0] r_free_head;
    logic [CW-1:0] r_fresh_fill, r_total;
    logic [LW-1:0] r_lowest;
    logic [15:0]   r_key;
    logic [31:0]   r_value;
    logic [BW-1:0] r_b;
    logic [EW-1:0] r_e;
    logic [EW-1:0] r_top_q, r_link_q;
    logic [CW-1:0] r_cnt_q;
    logic [31:0]   r_val_q;
    logic          r_ovalid;
    logic [31:0]   r_oval;
    logic [9:0]    r_okey;
    t_status       r_ost;

    // memory read addresses
    logic [BW-1:0] w_baddr;
    logic [EW-1:0] w_eaddr;
    logic          w_acc;
    logic [15:0]   w_in_key;
    logic          w_bv;

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_in_key = s_axis_tdata[16:1];
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {4'd0, r_ost, r_okey, r_oval};
    assign w_bv = (r_cnt_q != '0);

    always_comb begin
        if (r_state == S_IDLE) begin
            if (s_axis_tdata[0] == FUNC_PUSH) begin
                w_baddr = w_in_key[BW-1:0];
            end else begin
                w_baddr = r_lowest[BW-1:0];
            end
        end else if (r_state == S_SCAN) begin
            w_baddr = w_bv ? r_b : r_b + BW'(1);
        end else begin
            w_baddr = r_b;
        end
        w_eaddr = (r_state == S_POPT) ? r_top_q : r_free_head;
    end

    // bucket and entry memory reads, registered from the address
    always_ff @(posedge i_clk) begin
        r_top_q <= bucket_top[w_baddr];
        r_cnt_q <= bucket_count[w_baddr];
        r_link_q <= entry_link[w_eaddr];
        r_val_q <= entry_value[w_eaddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            bucket_count[r_b] <= '0;
        end else if (r_state == S_PUSHW) begin
            bucket_top[r_b] <= r_e;
            bucket_count[r_b] <= r_cnt_q + CW'(1);
            entry_value[r_e] <= r_value;
            entry_link[r_e] <= r_top_q;
        end else if (r_state == S_POPE) begin
            bucket_top[r_b] <= r_link_q;
            bucket_count[r_b] <= r_cnt_q - CW'(1);
            entry_link[r_e] <= r_free_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_b <= '0;
            r_free_head <= '0;
            r_fresh_fill <= '0;
            r_total <= '0;
            r_lowest <= LW'(NUM_BUCKETS);
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_b == BW'(NUM_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_b <= r_b + BW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_key <= w_in_key;
                        r_value <= s_axis_tdata[48:17];
                        r_b <= (s_axis_tdata[0] == FUNC_PUSH) ? w_in_key[BW-1:0]
                                                            : r_lowest[BW-1:0];
                        if (s_axis_tdata[0] == FUNC_PUSH) begin
                            if (32'(w_in_key) >= 32'(NUM_BUCKETS)) begin
                                r_ost <= ST_RANGE;
                                r_state <= S_OUT;
                            end else if (r_total == CW'(CAPACITY)) begin
                                r_ost <= ST_FULL;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_PUSH;
                            end
                        end else if (r_total == '0) begin
                            r_ost <= ST_EMPTY;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_PUSH: begin
                    // free list link of the head is valid now
                    if (r_fresh_fill > r_total) begin
                        r_e <= r_free_head;
                        r_free_head <= r_link_q;
                    end else begin
                        r_e <= r_fresh_fill[EW-1:0];
                        r_fresh_fill <= r_fresh_fill + CW'(1);
                    end
                    r_state <= S_PUSHW;
                end
                S_PUSHW: begin
                    r_total <= r_total + CW'(1);
                    if (LW'(r_key) < r_lowest) begin
                        r_lowest <= LW'(r_key);
                    end
                    r_ost <= ST_DONE;
                    r_state <= S_OUT;
                end
                S_SCAN: begin
                    if (w_bv) begin
                        r_lowest <= LW'(r_b);
                        r_state <= S_POPT;
                    end else begin
                        r_b <= r_b + BW'(1);
                    end
                end
                S_POPT: begin
                    r_e <= r_top_q;
                    r_state <= S_POPE;
                end
                S_POPE: begin
                    r_free_head <= r_e;
                    r_total <= r_total - CW'(1);
                    r_ost <= ST_DONE;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_acc) begin
            r_oval <= '0;
            r_okey <= '0;
        end else if (r_state == S_POPE) begin
            r_oval <= r_val_q;
            r_okey <= 10'(r_b);
        end
    end

endmodule
